// ===== src/bpc_pkg.sv =====
// bpc_pkg: shared types and constants for the button press classifier.
// No dependencies.
`timescale 1ns / 1ps

package bpc_pkg;

    localparam int CNT_W   = 16;
    localparam int LEVEL_W = 8;
    localparam int CFG_AW  = 2;

    localparam logic [CNT_W-1:0] CNT_MAX          = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] DEBOUNCE_RST     = 16'd80;
    localparam logic [CNT_W-1:0] SHORT_MAX_RST    = 16'd1500;
    localparam logic [CNT_W-1:0] LONG_RST         = 16'd3000;

    typedef enum logic [CFG_AW-1:0] {
        REG_DEBOUNCE  = 2'd0,
        REG_SHORT_MAX = 2'd1,
        REG_LONG      = 2'd2
    } bpc_reg_idx_t;

    typedef struct packed {
        logic [CNT_W-1:0] debounce_ticks;
        logic [CNT_W-1:0] short_max_ticks;
        logic [CNT_W-1:0] long_ticks;
    } bpc_cfg_t;

    typedef struct packed {
        logic short_hit;
        logic long_hit;
    } bpc_flags_t;

endpackage

// ===== src/bpc_lane.sv =====
// bpc_lane: per-button debounce and hold timer, flags short and long presses.
// Depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_lane
    import bpc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic       level,
    input  bpc_cfg_t   cfg,
    output bpc_flags_t flags
);

    logic             prev_level_reg, prev_level_next;
    logic [CNT_W-1:0] since_reg, since_next;
    logic [CNT_W-1:0] hold_reg, hold_next;
    logic             pressing_reg, pressing_next;
    logic             long_done_reg, long_done_next;

    logic [CNT_W-1:0] since_inc;
    logic [CNT_W-1:0] hold_inc;

    always_comb begin
        since_inc = (since_reg == CNT_MAX) ? CNT_MAX : since_reg + 1'b1;
        hold_inc  = hold_reg;
        if (pressing_reg && hold_reg != CNT_MAX) begin
            hold_inc = hold_reg + 1'b1;
        end

        prev_level_next = level;
        since_next      = since_inc;
        hold_next       = hold_inc;
        pressing_next   = pressing_reg;
        long_done_next  = long_done_reg;
        flags           = '0;

        if (level != prev_level_reg) begin
            if (!level) begin
                // falling edge: only a press once the debounce window has run out
                if (since_inc >= cfg.debounce_ticks) begin
                    pressing_next  = 1'b1;
                    hold_next      = '0;
                    long_done_next = 1'b0;
                    since_next     = '0;
                end
            end else begin
                flags.short_hit = pressing_reg && !long_done_reg &&
                                  (hold_inc < cfg.short_max_ticks);
                pressing_next   = 1'b0;
            end
        end else if (!level && pressing_reg && !long_done_reg) begin
            if (hold_inc >= cfg.long_ticks) begin
                long_done_next = 1'b1;
                flags.long_hit = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_level_reg <= 1'b1;
            since_reg      <= '0;
            hold_reg       <= '0;
            pressing_reg   <= 1'b0;
            long_done_reg  <= 1'b0;
        end else if (en) begin
            prev_level_reg <= prev_level_next;
            since_reg      <= since_next;
            hold_reg       <= hold_next;
            pressing_reg   <= pressing_next;
            long_done_reg  <= long_done_next;
        end
    end

endmodule

// ===== src/bpc_merge.sv =====
// bpc_merge: gathers lane flags into the two masks and holds the result register.
// Depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_merge
    import bpc_pkg::*;
#(
    parameter int BUTTONS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  logic               take,
    input  bpc_flags_t         lane_flags [BUTTONS],
    output logic               out_valid,
    output logic [LEVEL_W-1:0] short_mask,
    output logic [LEVEL_W-1:0] long_mask
);

    logic               valid_reg, valid_next;
    logic [LEVEL_W-1:0] short_reg, short_next;
    logic [LEVEL_W-1:0] long_reg, long_next;

    // only the first LEVEL_W lanes reach the masks
    for (genvar i = 0; i < LEVEL_W; i++) begin : g_bit
        if (i < BUTTONS) begin : g_lane
            assign short_next[i] = lane_flags[i].short_hit;
            assign long_next[i]  = lane_flags[i].long_hit;
        end else begin : g_none
            assign short_next[i] = 1'b0;
            assign long_next[i]  = 1'b0;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            short_reg <= short_next;
            long_reg  <= long_next;
        end
    end

    assign out_valid  = valid_reg;
    assign short_mask = short_reg;
    assign long_mask  = long_reg;

endmodule

// ===== src/button_press_classifier.sv =====
// button_press_classifier: top level, config registers, one lane per button, merge.
// Depends on bpc_pkg, bpc_lane, bpc_merge.
`timescale 1ns / 1ps
//
// channel | ports                                 | direction
// s_      | s_valid, s_ready, s_button_levels     | tick in
// m_      | m_valid, m_ready, m_short_mask,       | masks out
//         | m_long_mask                           |
// cfg_    | cfg_we, cfg_addr, cfg_wdata           | register write
//
// One tick per cycle while m_ready does not stall the output; its masks appear in the cycle after the transfer.
// All lanes update in the accept cycle; the single output register sets latency.
// s_ready is high while the output register is empty or being taken.
// Synchronous active-low reset restores defaults and clears all lane state.

module button_press_classifier
    import bpc_pkg::*;
#(
    parameter int BUTTONS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [LEVEL_W-1:0] s_button_levels,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [LEVEL_W-1:0] m_short_mask,
    output logic [LEVEL_W-1:0] m_long_mask,
    input  logic               cfg_we,
    input  logic [CFG_AW-1:0]  cfg_addr,
    input  logic [CNT_W-1:0]   cfg_wdata
);

    bpc_cfg_t   cfg_reg, cfg_next;
    bpc_flags_t lane_flags [BUTTONS];
    logic       accept;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_DEBOUNCE:  cfg_next.debounce_ticks  = cfg_wdata;
                REG_SHORT_MAX: cfg_next.short_max_ticks = cfg_wdata;
                REG_LONG:      cfg_next.long_ticks      = cfg_wdata;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks  <= DEBOUNCE_RST;
            cfg_reg.short_max_ticks <= SHORT_MAX_RST;
            cfg_reg.long_ticks      <= LONG_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_ready = !m_valid || m_ready;
    assign accept  = s_valid && s_ready;

    for (genvar i = 0; i < BUTTONS; i++) begin : g_lane
        logic lane_level;
        // buttons past the input width stay released
        if (i < LEVEL_W) begin : g_in
            assign lane_level = s_button_levels[i];
        end else begin : g_idle
            assign lane_level = 1'b1;
        end

        bpc_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (accept),
            .level   (lane_level),
            .cfg     (cfg_reg),
            .flags   (lane_flags[i])
        );
    end

    bpc_merge #(
        .BUTTONS (BUTTONS)
    ) u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (accept),
        .take       (m_ready),
        .lane_flags (lane_flags),
        .out_valid  (m_valid),
        .short_mask (m_short_mask),
        .long_mask  (m_long_mask)
    );

endmodule

// ===== dv/bpc_mask_checker.sv =====
// bpc_mask_checker: watches the tick, mask and register channels of the classifier,
// predicts the short and long masks of every tick and compares them. Depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_mask_checker
    import bpc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [LEVEL_W-1:0] s_button_levels,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [LEVEL_W-1:0] m_short_mask,
    input  logic [LEVEL_W-1:0] m_long_mask,
    input  logic               cfg_we,
    input  logic [CFG_AW-1:0]  cfg_addr,
    input  logic [CNT_W-1:0]   cfg_wdata,
    output int                 fail_count,
    output int                 outstanding
);

    typedef struct packed {
        logic [LEVEL_W-1:0] short_m;
        logic [LEVEL_W-1:0] long_m;
    } press_masks_t;

    press_masks_t     expected_masks[$];
    bpc_cfg_t         cfg;
    logic [CNT_W-1:0] ticks_since_press [LEVEL_W];
    logic [CNT_W-1:0] ticks_held        [LEVEL_W];
    logic             last_level        [LEVEL_W];
    logic             held              [LEVEL_W];
    logic             long_fired        [LEVEL_W];

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    task automatic clear_buttons();
        cfg.debounce_ticks  = DEBOUNCE_RST;
        cfg.short_max_ticks = SHORT_MAX_RST;
        cfg.long_ticks      = LONG_RST;
        for (int b = 0; b < LEVEL_W; b++) begin
            ticks_since_press[b] = '0;
            ticks_held[b]        = '0;
            last_level[b]        = 1'b1;
            held[b]              = 1'b0;
            long_fired[b]        = 1'b0;
        end
    endtask

    // One tick: counters advance first (saturating), then the edge decides.
    task automatic classify_tick(input logic [LEVEL_W-1:0] lv, output press_masks_t res);
        logic now_lvl;
        res = '0;
        for (int b = 0; b < LEVEL_W; b++) begin
            now_lvl = lv[b];
            if (ticks_since_press[b] != CNT_MAX)
                ticks_since_press[b] = ticks_since_press[b] + 1'b1;
            if (held[b] && ticks_held[b] != CNT_MAX)
                ticks_held[b] = ticks_held[b] + 1'b1;
            if (now_lvl != last_level[b]) begin
                if (!now_lvl) begin
                    // a press inside the debounce window is swallowed
                    if (ticks_since_press[b] >= cfg.debounce_ticks) begin
                        held[b]              = 1'b1;
                        ticks_held[b]        = '0;
                        long_fired[b]        = 1'b0;
                        ticks_since_press[b] = '0;
                    end
                end else begin
                    if (held[b] && !long_fired[b] && ticks_held[b] < cfg.short_max_ticks)
                        res.short_m[b] = 1'b1;
                    held[b] = 1'b0;
                end
                last_level[b] = now_lvl;
            end else if (!now_lvl && held[b] && !long_fired[b] &&
                         ticks_held[b] >= cfg.long_ticks) begin
                long_fired[b]  = 1'b1;
                res.long_m[b]  = 1'b1;
            end
        end
    endtask

    always @(posedge aclk) begin : watch
        press_masks_t want;
        press_masks_t next_m;
        if (!aresetn) begin
            clear_buttons();
            expected_masks.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_masks.size() == 0) begin
                    fail_count = fail_count + 1;
                    $display("%0t: mask transfer with nothing expected, short %h long %h",
                             $time, m_short_mask, m_long_mask);
                end else begin
                    want = expected_masks.pop_front();
                    if (m_short_mask !== want.short_m) begin
                        fail_count = fail_count + 1;
                        $display("%0t: short_mask expected %h actual %h",
                                 $time, want.short_m, m_short_mask);
                    end
                    if (m_long_mask !== want.long_m) begin
                        fail_count = fail_count + 1;
                        $display("%0t: long_mask expected %h actual %h",
                                 $time, want.long_m, m_long_mask);
                    end
                end
            end
            if (s_valid && s_ready) begin
                classify_tick(s_button_levels, next_m);
                expected_masks.push_back(next_m);
            end
            // a write lands after any tick taken at the same edge
            if (cfg_we) begin
                case (cfg_addr)
                    REG_DEBOUNCE:  cfg.debounce_ticks  = cfg_wdata;
                    REG_SHORT_MAX: cfg.short_max_ticks = cfg_wdata;
                    REG_LONG:      cfg.long_ticks      = cfg_wdata;
                    default: ;
                endcase
            end
        end
        outstanding <= expected_masks.size();
    end

endmodule

// ===== dv/button_press_classifier_tb.sv =====
// button_press_classifier_tb: clock, reset, tick stimulus, register programming and verdict.
// Depends on bpc_pkg, button_press_classifier and bpc_mask_checker.
`timescale 1ns / 1ps

module button_press_classifier_tb
    import bpc_pkg::*;
();

    localparam logic [CFG_AW-1:0] REG_UNUSED = 2'd3;
    localparam int HOLDOFF_CYCLES = 200;
    localparam int SAT_SPAN       = 16;

    logic               aclk            = 1'b0;
    logic               aresetn         = 1'b0;
    logic               s_valid         = 1'b0;
    logic               s_ready;
    logic [LEVEL_W-1:0] s_button_levels = '1;
    logic               m_valid;
    logic               m_ready         = 1'b0;
    logic [LEVEL_W-1:0] m_short_mask;
    logic [LEVEL_W-1:0] m_long_mask;
    logic               cfg_we          = 1'b0;
    logic [CFG_AW-1:0]  cfg_addr        = '0;
    logic [CNT_W-1:0]   cfg_wdata       = '0;

    int fail_count;
    int outstanding;

    bit rx_quiet    = 1'b0;
    bit rx_hold_req = 1'b0;

    // stimulus shaping only: current settings and per-button levels
    int                 cur_deb   = 80;
    int                 cur_short = 1500;
    int                 cur_long  = 3000;
    logic [LEVEL_W-1:0] btn_level = '1;
    int                 btn_left [LEVEL_W];

    button_press_classifier uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_button_levels (s_button_levels),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_short_mask    (m_short_mask),
        .m_long_mask     (m_long_mask),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata)
    );

    bpc_mask_checker mask_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_button_levels (s_button_levels),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_short_mask    (m_short_mask),
        .m_long_mask     (m_long_mask),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .outstanding     (outstanding)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("[button_press_classifier] ERROR");
        $finish;
    end

    // mask receiver: random stalls, a long hold-off on request, none when quiet
    initial begin
        forever begin
            if (rx_hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge aclk);
                rx_hold_req = 1'b0;
            end else if (rx_quiet) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
                if ($urandom_range(0, 1)) begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(1, 15)) @(posedge aclk);
                end
            end
        end
    end

    task automatic send_tick(input logic [LEVEL_W-1:0] lv);
        s_valid         <= 1'b1;
        s_button_levels <= lv;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic sender_gap();
        s_valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge aclk);
    endtask

    // the count seen here is registered, so let the last transfer register first
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic reconfigure(input int deb, input int sh, input int lg, input bit poke);
        drain();
        repeat (3) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_DEBOUNCE;
        cfg_wdata <= CNT_W'(deb);
        @(posedge aclk);
        cfg_addr  <= REG_SHORT_MAX;
        cfg_wdata <= CNT_W'(sh);
        @(posedge aclk);
        cfg_addr  <= REG_LONG;
        cfg_wdata <= CNT_W'(lg);
        @(posedge aclk);
        if (poke) begin
            // index with no register behind it: must change nothing
            cfg_addr  <= REG_UNUSED;
            cfg_wdata <= CNT_W'($urandom);
            @(posedge aclk);
        end
        cfg_we    <= 1'b0;
        cur_deb   = deb;
        cur_short = sh;
        cur_long  = lg;
    endtask

    // level duration, mostly close to the thresholds that matter
    function automatic int hold_span();
        int span;
        case ($urandom_range(0, 4))
            0:       span = $urandom_range(1, 2);
            1:       span = cur_short - 2 + int'($urandom_range(0, 4));
            2:       span = cur_long - 2 + int'($urandom_range(0, 4));
            3:       span = cur_deb - 2 + int'($urandom_range(0, 4));
            default: span = 1 + int'($urandom_range(0, cur_long + cur_short + 5));
        endcase
        if (span < 1) span = 1;
        return span;
    endfunction

    task automatic run_random(input int n, input bit idle, input int hold_at, input int pause_at);
        logic [LEVEL_W-1:0] lv;
        for (int b = 0; b < LEVEL_W; b++) btn_left[b] = hold_span();
        for (int k = 0; k < n; k++) begin
            if (k == hold_at) rx_hold_req = 1'b1;
            if (k == pause_at) drain();
            if ($urandom_range(0, 19) == 0) begin
                lv = LEVEL_W'($urandom_range(0, 255));
            end else begin
                for (int b = 0; b < LEVEL_W; b++) begin
                    if (btn_left[b] == 0) begin
                        btn_level[b] = ~btn_level[b];
                        btn_left[b]  = hold_span();
                    end
                    btn_left[b]--;
                end
                lv = btn_level;
            end
            send_tick(lv);
            if (idle && $urandom_range(0, 5) == 0) sender_gap();
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: first press falls inside the debounce window
        send_tick(8'h00);
        send_tick(8'hFF);

        // long threshold zero: fires the tick after the press, no short on release
        reconfigure(0, 2, 0, 1'b1);
        send_tick(8'h00);
        send_tick(8'h00);
        send_tick(8'hFF);

        reconfigure(0, 2, 5, 1'b0);
        send_tick(8'h00);
        send_tick(8'hFF);
        send_tick(8'h00);
        send_tick(8'h00);
        send_tick(8'hFF);
        send_tick(8'hAA);
        send_tick(8'h55);
        send_tick(8'hAA);
        send_tick(8'h55);
        send_tick(8'hFF);

        reconfigure(0, 0, 16'hFFFF, 1'b0);
        send_tick(8'h00);
        send_tick(8'hFF);

        reconfigure(3, 6, 12, 1'b1);
        run_random(150, 1'b1, 50, -1);
        reconfigure(0, 0, 0, 1'b0);
        run_random(150, 1'b1, -1, 75);
        reconfigure(10, 25, 40, 1'b0);
        run_random(150, 1'b1, 60, -1);
        reconfigure($urandom_range(0, 8), $urandom_range(0, 20), $urandom_range(0, 30), 1'b1);
        run_random(150, 1'b1, -1, -1);

        // top settings: every press stays inside the debounce window, no idling from here on
        rx_quiet = 1'b1;
        reconfigure(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        repeat (SAT_SPAN) send_tick(8'hFF);
        repeat (SAT_SPAN) send_tick(8'h00);
        send_tick(8'hFF);
        send_tick(8'h00);
        send_tick(8'hFF);
        repeat (SAT_SPAN) send_tick(8'hFF);
        send_tick(8'h00);
        send_tick(8'hFF);

        reconfigure(1, 4, 9, 1'b1);
        run_random(150, 1'b0, -1, -1);

        drain();
        repeat (5) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[button_press_classifier] OK");
        end else begin
            $display("[button_press_classifier] ERROR");
        end
        $finish;
    end

endmodule
